FILE: rtl/ufx_pkg.sv
package ufx_pkg;

   localparam logic [2:0] KIND_RX_BYTE = 3'd0;
   localparam logic [2:0] KIND_HOST_READ = 3'd1;
   localparam logic [2:0] KIND_HOST_FLUSH = 3'd2;
   localparam logic [2:0] KIND_HOST_WRITE = 3'd3;
   localparam logic [2:0] KIND_TX_SLOT = 3'd4;

   localparam logic [2:0] CSR_FLOW_ENABLE = 3'd0;
   localparam logic [2:0] CSR_XOFF_LEVEL = 3'd1;
   localparam logic [2:0] CSR_XON_LEVEL = 3'd2;
   localparam logic [2:0] CSR_COUNT_DROPS = 3'd3;
   localparam logic [2:0] CSR_COUNT_OVERRUNS = 3'd4;
   localparam logic [2:0] CSR_COUNT_FRAMING = 3'd5;
   localparam logic [2:0] CSR_TRACK_PEAK = 3'd6;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 7;

   localparam logic [7:0] CHAR_XON = 8'h11;
   localparam logic [7:0] CHAR_XOFF = 8'h13;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic overrun_flag;
      logic framing_flag;
   } ufx_req_type;

   typedef struct packed {
      logic read_valid;
      logic [7:0] read_data;
      logic [6:0] rx_fill;
      logic tx_valid;
      logic [7:0] tx_data;
      logic write_refused;
      logic [7:0] dropped_total;
      logic [7:0] overrun_total;
      logic [7:0] framing_total;
      logic [6:0] peak_fill;
      logic xoff_active;
   } ufx_rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ufx_cmd_type;

endpackage

FILE: rtl/ufx_ctrl.sv
module ufx_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   output ufx_pkg::ufx_cmd_type cmd
);
   import ufx_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic exec_go;

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign accept = req_valid && req_ready;
   // result register must be free (or emptying) before the update lands
   assign exec_go = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign cmd.load = accept;
   assign cmd.exec = exec_go;

endmodule

FILE: rtl/ufx_datapath.sv
module ufx_datapath #(
   parameter int unsigned RX_DEPTH = 128,
   parameter int unsigned TX_DEPTH = 32
) (
   input logic clock,
   input logic reset,
   input ufx_pkg::ufx_cmd_type cmd,
   input ufx_pkg::ufx_req_type req_payload,
   output ufx_pkg::ufx_rsp_type rsp_payload,
   input logic csr_wr_en,
   input logic [ufx_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [ufx_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ufx_pkg::*;

   localparam int unsigned RXP = $clog2(RX_DEPTH);
   localparam int unsigned TXP = $clog2(TX_DEPTH);
   localparam int unsigned CW = (RXP > 7) ? RXP : 7;

   typedef enum logic [1:0] {
      FLOW_XON_SENT,
      FLOW_XON_PENDING,
      FLOW_XOFF_SENT
   } flow_type;

   logic [7:0] rx_mem [RX_DEPTH];
   logic [7:0] tx_mem [TX_DEPTH];

   logic flow_en_ff;
   logic [6:0] xoff_lvl_ff;
   logic [6:0] xon_lvl_ff;
   logic cnt_drop_ff;
   logic cnt_ovr_ff;
   logic cnt_fe_ff;
   logic trk_peak_ff;

   ufx_req_type item_ff;
   logic [7:0] rx_rdata_ff;
   logic [7:0] tx_rdata_ff;
   ufx_rsp_type rsp_ff, rsp_in;

   logic [RXP-1:0] rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic [TXP-1:0] tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   flow_type flow_ff, flow_in;
   logic [7:0] drop_ff, drop_in;
   logic [7:0] ovr_ff, ovr_in;
   logic [7:0] fe_ff, fe_in;
   logic [6:0] peak_ff, peak_in;

   logic rx_we, tx_we;
   logic [RXP-1:0] fill_old, fill_rx, fill_rd, fill_new;
   logic rx_full, rx_empty, tx_full, tx_empty;
   logic [1:0] drop_inc;
   logic [6:0] fill_rx_clip;

   function automatic logic [RXP-1:0] rx_next(input logic [RXP-1:0] p);
      return (p == RXP'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [TXP-1:0] tx_next(input logic [TXP-1:0] p);
      return (p == TXP'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [RXP-1:0] fill_of(input logic [RXP-1:0] wr,
                                              input logic [RXP-1:0] rd);
      logic [RXP:0] diff;
      diff = {1'b0, wr} - {1'b0, rd};
      if (wr < rd) begin
         diff = diff + (RXP+1)'(RX_DEPTH);
      end
      return diff[RXP-1:0];
   endfunction

   function automatic logic [6:0] clip7(input logic [RXP-1:0] f);
      logic [CW-1:0] w;
      w = CW'(f);
      return (w > CW'(127)) ? 7'd127 : w[6:0];
   endfunction

   function automatic logic [7:0] sat8(input logic [7:0] v, input logic [1:0] inc);
      logic [8:0] s;
      s = {1'b0, v} + {7'd0, inc};
      return (s > 9'd255) ? 8'd255 : s[7:0];
   endfunction

   assign fill_old = fill_of(rx_wr_ff, rx_rd_ff);
   assign rx_full = (rx_next(rx_wr_ff) == rx_rd_ff);
   assign rx_empty = (rx_wr_ff == rx_rd_ff);
   assign tx_full = (tx_next(tx_wr_ff) == tx_rd_ff);
   assign tx_empty = (tx_wr_ff == tx_rd_ff);
   assign fill_rx = rx_full ? fill_old : fill_old + 1'b1;
   assign fill_rd = fill_old - 1'b1;
   assign fill_rx_clip = clip7(fill_rx);
   assign drop_inc = {1'b0, cnt_drop_ff && item_ff.overrun_flag}
                     + {1'b0, cnt_drop_ff && rx_full};

   always_comb begin
      rx_wr_in = rx_wr_ff;
      rx_rd_in = rx_rd_ff;
      tx_wr_in = tx_wr_ff;
      tx_rd_in = tx_rd_ff;
      flow_in = flow_ff;
      drop_in = drop_ff;
      ovr_in = ovr_ff;
      fe_in = fe_ff;
      peak_in = peak_ff;
      rx_we = 1'b0;
      tx_we = 1'b0;
      fill_new = fill_old;
      rsp_in = '0;
      case (item_ff.kind)
         KIND_RX_BYTE: begin
            drop_in = sat8(drop_ff, drop_inc);
            if (cnt_ovr_ff && item_ff.overrun_flag) begin
               ovr_in = sat8(ovr_ff, 2'd1);
            end
            if (cnt_fe_ff && item_ff.framing_flag) begin
               fe_in = sat8(fe_ff, 2'd1);
            end
            if (!rx_full) begin
               rx_we = 1'b1;
               rx_wr_in = rx_next(rx_wr_ff);
            end
            fill_new = fill_rx;
            if (trk_peak_ff && (fill_rx_clip > peak_ff)) begin
               peak_in = fill_rx_clip;
            end
            if (flow_en_ff && (flow_ff != FLOW_XOFF_SENT)
                && (CW'(fill_rx) >= CW'(xoff_lvl_ff))) begin
               flow_in = FLOW_XOFF_SENT;
               rsp_in.tx_valid = 1'b1;
               rsp_in.tx_data = CHAR_XOFF;
            end
         end
         KIND_HOST_READ: begin
            if (!rx_empty) begin
               rsp_in.read_valid = 1'b1;
               rsp_in.read_data = rx_rdata_ff;
               rx_rd_in = rx_next(rx_rd_ff);
               fill_new = fill_rd;
               if (flow_en_ff && (flow_ff == FLOW_XOFF_SENT)
                   && (CW'(fill_rd) < CW'(xon_lvl_ff))) begin
                  flow_in = FLOW_XON_PENDING;
               end
            end
         end
         KIND_HOST_FLUSH: begin
            rx_rd_in = rx_wr_ff;
            fill_new = '0;
            if (flow_en_ff && (flow_ff == FLOW_XOFF_SENT)) begin
               flow_in = FLOW_XON_PENDING;
            end
         end
         KIND_HOST_WRITE: begin
            if (tx_full) begin
               rsp_in.write_refused = 1'b1;
            end else begin
               tx_we = 1'b1;
               tx_wr_in = tx_next(tx_wr_ff);
            end
         end
         KIND_TX_SLOT: begin
            if (flow_en_ff && (flow_ff == FLOW_XON_PENDING)) begin
               rsp_in.tx_valid = 1'b1;
               rsp_in.tx_data = CHAR_XON;
               flow_in = FLOW_XON_SENT;
            end else if (!tx_empty) begin
               rsp_in.tx_valid = 1'b1;
               rsp_in.tx_data = tx_rdata_ff;
               tx_rd_in = tx_next(tx_rd_ff);
            end
         end
         default: begin
         end
      endcase
      rsp_in.rx_fill = clip7(fill_new);
      rsp_in.dropped_total = drop_in;
      rsp_in.overrun_total = ovr_in;
      rsp_in.framing_total = fe_in;
      rsp_in.peak_fill = peak_in;
      rsp_in.xoff_active = (flow_in == FLOW_XOFF_SENT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_en_ff <= 1'b1;
         xoff_lvl_ff <= 7'd16;
         xon_lvl_ff <= 7'd12;
         cnt_drop_ff <= 1'b1;
         cnt_ovr_ff <= 1'b1;
         cnt_fe_ff <= 1'b1;
         trk_peak_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FLOW_ENABLE: flow_en_ff <= csr_wdata[0];
            CSR_XOFF_LEVEL: xoff_lvl_ff <= csr_wdata[6:0];
            CSR_XON_LEVEL: xon_lvl_ff <= csr_wdata[6:0];
            CSR_COUNT_DROPS: cnt_drop_ff <= csr_wdata[0];
            CSR_COUNT_OVERRUNS: cnt_ovr_ff <= csr_wdata[0];
            CSR_COUNT_FRAMING: cnt_fe_ff <= csr_wdata[0];
            CSR_TRACK_PEAK: trk_peak_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ff <= '0;
         rx_rd_ff <= '0;
         tx_wr_ff <= '0;
         tx_rd_ff <= '0;
         flow_ff <= FLOW_XON_SENT;
         drop_ff <= '0;
         ovr_ff <= '0;
         fe_ff <= '0;
         peak_ff <= '0;
      end else if (cmd.exec) begin
         rx_wr_ff <= rx_wr_in;
         rx_rd_ff <= rx_rd_in;
         tx_wr_ff <= tx_wr_in;
         tx_rd_ff <= tx_rd_in;
         flow_ff <= flow_in;
         drop_ff <= drop_in;
         ovr_ff <= ovr_in;
         fe_ff <= fe_in;
         peak_ff <= peak_in;
      end
   end

   // ring storage and payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
         rx_rdata_ff <= rx_mem[rx_rd_ff];
         tx_rdata_ff <= tx_mem[tx_rd_ff];
      end
      if (cmd.exec && rx_we) begin
         rx_mem[rx_wr_ff] <= item_ff.data;
      end
      if (cmd.exec && tx_we) begin
         tx_mem[tx_wr_ff] <= item_ff.data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/uart_fifo_xon_xoff.sv
// Serial-port buffer pair (RX and TX rings) with XON/XOFF flow control.
// Request channel (req_*): one event per request - received byte, host read,
// host flush, host write or transmit slot - with the receiver error flags.
// Response channel (rsp_*): exactly one response per request, carrying the
// popped byte, the byte for the transmitter, RX fill, the saturating drop,
// overrun and framing counts, peak fill and the XOFF status.
// An accepted request first has both rings' synchronous memories read at
// their read pointers into registers; the update step then changes pointers,
// counters and flow state once the response register is free. A new request
// is taken only after the update of the previous one.
// A new request is taken while the previous response still waits; if the
// receiver stalls, the update cycle holds until the response register empties.
// Each ring holds depth minus one bytes.
// Reset: rings empty, counters and peak cleared, flow state XON sent, and all
// configuration registers at their defaults. Ring contents are not cleared.
// Users write configuration (csr_*) only while the block is idle; unenforced.
module uart_fifo_xon_xoff #(
   parameter int unsigned RX_DEPTH = 128,
   parameter int unsigned TX_DEPTH = 32
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input ufx_pkg::ufx_req_type req_payload,
   output logic rsp_valid,
   input logic rsp_ready,
   output ufx_pkg::ufx_rsp_type rsp_payload,
   input logic csr_wr_en,
   input logic [ufx_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [ufx_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ufx_pkg::*;

   ufx_cmd_type cmd;

   ufx_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd(cmd)
   );

   ufx_datapath #(
      .RX_DEPTH(RX_DEPTH),
      .TX_DEPTH(TX_DEPTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .req_payload(req_payload),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

endmodule
